// ===== rtl/core/hpa_pkg.sv =====
package hpa_pkg;

    localparam int POOL_SIZE_DEF = 256;
    localparam int HANDLE_W      = 8;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int HANDLE_SPACE  = 2 ** HANDLE_W;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRY     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef logic [HANDLE_W-1:0] t_handle;

    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } t_q_ctl;

    typedef struct packed {
        logic rd;
        logic wr;
        logic set;
    } t_map_ctl;

    // only handles below the handle space can ever be released
    function automatic int queue_depth(input int pool);
        return (pool < HANDLE_SPACE) ? pool : HANDLE_SPACE;
    endfunction

endpackage

// ===== rtl/core/hpa_free_queue.sv =====
module hpa_free_queue #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hpa_pkg::t_q_ctl i_ctl,
    input  hpa_pkg::t_handle i_push_data,
    output hpa_pkg::t_handle o_head_data,
    output logic            o_empty
);
    import hpa_pkg::*;

    t_handle       mem [DEPTH];
    t_handle       r_rdata;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_tail] <= i_push_data;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.pop) begin
                r_head  <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                r_count <= r_count - (AW + 1)'(1);
            end else if (i_ctl.push) begin
                r_tail  <= (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
                r_count <= r_count + (AW + 1)'(1);
            end
        end
    end

    assign o_head_data = r_rdata;
    assign o_empty     = (r_count == '0);

endmodule

// ===== rtl/core/hpa_alloc_map.sv =====
module hpa_alloc_map #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  hpa_pkg::t_map_ctl i_ctl,
    input  logic [AW-1:0]     i_raddr,
    input  logic [AW-1:0]     i_waddr,
    output logic              o_bit
);
    import hpa_pkg::*;

    logic mem [DEPTH];
    logic r_rbit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_waddr] <= i_ctl.set;
        end
        if (i_ctl.rd) begin
            r_rbit <= mem[i_raddr];
        end
    end

    assign o_bit = r_rbit;

endmodule

// ===== rtl/core/handle_pool_allocator.sv =====
// handle pool allocator
//
// input channel: i_valid / o_stall carry one request word (i_mode, i_handle_in).
// a word is taken on a rising edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carry one result word (o_handle_out, o_status)
// for every request, in request order.
//
// each request is read, then decided: the free queue head and the allocated bit are read
// from their memories in the accept cycle, and the decision and write-back happen once
// the output register is free. no new request is taken until that decision is made.
// o_valid rises at the edge that writes the decision into the output register.
//
// when i_stall holds the output, the word stays unchanged in the output register and
// one more request may still be taken; it then waits, memories untouched, until the
// output register frees up. o_stall is high during reset.
// reset empties the free queue and the pool of minted handles; the allocated bitmap
// needs no clearing pass, since a bit is only trusted for handles already minted.
module handle_pool_allocator #(
    parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hpa_pkg::MODE_W-1:0]   i_mode,
    input  hpa_pkg::t_handle             i_handle_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output hpa_pkg::t_handle             o_handle_out,
    output logic [hpa_pkg::STATUS_W-1:0] o_status
);
    import hpa_pkg::*;

    localparam int QDEPTH = queue_depth(POOL_SIZE);
    localparam int QAW    = $clog2(QDEPTH);
    localparam int FW     = $clog2(POOL_SIZE + 1);

    logic                r_busy;
    logic                r_ovalid;
    logic [MODE_W-1:0]   r_mode;
    t_handle             r_handle;
    logic [FW-1:0]       r_fresh;
    logic [FW-1:0]       n_fresh;
    t_handle             r_ohandle;
    logic [STATUS_W-1:0] r_ostatus;

    logic                accept;
    logic                exec;
    t_q_ctl              q_ctl;
    t_map_ctl            map_ctl;
    logic [QAW-1:0]      map_waddr;
    t_handle             q_head;
    logic                q_empty;
    logic                map_bit;
    t_handle             res_handle;
    logic [STATUS_W-1:0] res_status;

    assign o_stall = r_busy | ~i_rst_n;
    assign accept  = i_valid & ~o_stall;
    assign exec    = r_busy & (~r_ovalid | ~i_stall);

    hpa_free_queue #(
        .DEPTH (QDEPTH),
        .AW    (QAW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (q_ctl),
        .i_push_data (r_handle),
        .o_head_data (q_head),
        .o_empty     (q_empty)
    );

    hpa_alloc_map #(
        .DEPTH (QDEPTH),
        .AW    (QAW)
    ) u_map (
        .i_clk   (i_clk),
        .i_ctl   (map_ctl),
        .i_raddr (i_handle_in[QAW-1:0]),
        .i_waddr (map_waddr),
        .o_bit   (map_bit)
    );

    always_comb begin
        q_ctl       = '0;
        q_ctl.rd    = accept;
        map_ctl     = '0;
        map_ctl.rd  = accept;
        map_waddr   = '0;
        n_fresh     = r_fresh;
        res_handle  = '0;
        res_status  = ST_OK;
        unique case (r_mode)
            MODE_ALLOC, MODE_TRY: begin
                if (!q_empty) begin
                    res_handle  = q_head;
                    q_ctl.pop   = exec;
                    map_ctl.wr  = exec;
                    map_ctl.set = 1'b1;
                    map_waddr   = q_head[QAW-1:0];
                end else if (r_mode == MODE_TRY) begin
                    res_status = ST_NONE;
                end else if (r_fresh < FW'(POOL_SIZE)) begin
                    res_handle  = HANDLE_W'(r_fresh);
                    // minted handles beyond the handle space are never read back
                    map_ctl.wr  = exec & (r_fresh < FW'(QDEPTH));
                    map_ctl.set = 1'b1;
                    map_waddr   = r_fresh[QAW-1:0];
                    if (exec) begin
                        n_fresh = r_fresh + FW'(1);
                    end
                end else begin
                    res_status = ST_EXHAUSTED;
                end
            end
            MODE_RELEASE: begin
                res_handle = r_handle;
                // a bit is only valid for handles already minted
                if ((32'(r_handle) < 32'(r_fresh)) && map_bit) begin
                    q_ctl.push  = exec;
                    map_ctl.wr  = exec;
                    map_ctl.set = 1'b0;
                    map_waddr   = r_handle[QAW-1:0];
                end else begin
                    res_status = ST_INVALID;
                end
            end
            default: begin
                res_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_fresh  <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_fresh <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_handle <= i_handle_in;
        end
        if (exec) begin
            r_ohandle <= res_handle;
            r_ostatus <= res_status;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_handle_out = r_ohandle;
    assign o_status     = r_ostatus;

endmodule

// ===== rtl/core/hpa_checker.sv =====
module hpa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [hpa_pkg::MODE_W-1:0]   i_mode,
    input hpa_pkg::t_handle             i_handle_in,
    input logic                         o_valid,
    input logic                         i_stall,
    input hpa_pkg::t_handle             o_handle_out,
    input logic [hpa_pkg::STATUS_W-1:0] o_status
);
    import hpa_pkg::*;

    // a held result word does not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_handle_out) && $stable(o_status))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // failed allocations carry a zero handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NONE || o_status == ST_EXHAUSTED) |-> o_handle_out == '0)
        else $error("failed allocation with non-zero handle");

    // one request in flight at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while previous still in work");

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (.*);
